@@ sv/deq_pkg.sv @@
// Shared types and codes for the double-ended queue.
// Holds operation codes, result kinds and the result descriptor struct.
// No dependencies.
`default_nettype none

package deq_pkg;

  // Operation codes carried by an input transaction
  localparam logic [2:0] FUNC_CLEAR      = 3'd0;
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd2;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd4;
  localparam logic [2:0] FUNC_RELEASE    = 3'd5;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_VALUE     = 2'd0,
    KIND_COUNT     = 2'd1,
    KIND_UNDERFLOW = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  // Result descriptor handed from the pointer logic to the output stage
  typedef struct packed {
    logic        valid;     // the operation gives a result
    logic        from_ram;  // take the value from the store read port
    kind_t       kind;
    logic [31:0] value;     // count or zero when not from the store
  } deq_meta_t;

endpackage

`default_nettype wire

@@ sv/deq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, register read data only when a read is asked for
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/deq_ctrl.sv @@
// Pointer and count control for the double-ended queue.
// Decodes each transaction, updates front pointer and count, drives the store.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [2:0]                  func,
  output logic                             wr_en,
  output logic                             rd_en,
  output logic [$clog2(CAPACITY)-1:0]      addr,
  output deq_pkg::deq_meta_t               meta
);
  import deq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] sum_back, sum_last, wrap_back, wrap_last;
  logic [AW-1:0] front_dec, front_inc;
  logic          full, empty;

  assign full  = (count >= CAP_C);
  assign empty = (count == '0);

  // Slot after the back, and the back slot itself, wrapped once
  assign sum_back  = SW'(front) + SW'(count);
  assign sum_last  = sum_back - SW'(1);
  assign wrap_back = (sum_back >= CAP_S) ? sum_back - CAP_S : sum_back;
  assign wrap_last = (sum_last >= CAP_S) ? sum_last - CAP_S : sum_last;
  assign front_dec = (front == '0) ? LAST_A : front - AW'(1);
  assign front_inc = (front == LAST_A) ? '0 : front + AW'(1);

  // Decode the operation
  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = front;
    meta       = '{valid: 1'b0, from_ram: 1'b0, kind: KIND_VALUE, value: 32'd0};
    case (func)
      FUNC_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      FUNC_PUSH_FRONT: begin
        if (full) begin
          meta.valid = 1'b1;
          meta.kind  = KIND_OVERFLOW;
        end else begin
          front_next = front_dec;
          count_next = count + CW'(1);
          addr       = front_dec;
          wr_en      = accept;
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          meta.valid = 1'b1;
          meta.kind  = KIND_OVERFLOW;
        end else begin
          count_next = count + CW'(1);
          addr       = AW'(wrap_back);
          wr_en      = accept;
        end
      end
      FUNC_POP_FRONT: begin
        meta.valid = 1'b1;
        if (empty) begin
          meta.kind = KIND_UNDERFLOW;
        end else begin
          meta.from_ram = 1'b1;
          front_next    = front_inc;
          count_next    = count - CW'(1);
          rd_en         = accept;
        end
      end
      FUNC_POP_BACK: begin
        meta.valid = 1'b1;
        if (empty) begin
          meta.kind = KIND_UNDERFLOW;
        end else begin
          meta.from_ram = 1'b1;
          count_next    = count - CW'(1);
          addr          = AW'(wrap_last);
          rd_en         = accept;
        end
      end
      FUNC_RELEASE: begin
        meta.valid = 1'b1;
        meta.kind  = KIND_COUNT;
        meta.value = 32'(count);
        front_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Advance the pointers on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/deq_out.sv @@
// Result stage and output register of the double-ended queue.
// Pairs the descriptor with store read data and drives the result channel.
// Depends on deq_pkg.
`default_nettype none

module deq_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire deq_pkg::deq_meta_t  meta,
  input  wire logic [31:0]         rd_data,
  output logic                     hold,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output logic signed [31:0]       result_value,
  output logic [1:0]               result_kind
);
  import deq_pkg::*;

  logic      s1_valid;
  deq_meta_t s1_meta;
  logic      out_free;

  assign out_free = !result_valid || !result_stall;
  // Hold the input side while the result stage cannot drain
  assign hold = s1_valid && !out_free;

  // Result stage, aligned with the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= meta.valid;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_meta <= meta;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      result_value <= s1_meta.from_ram ? rd_data : s1_meta.value;
      result_kind  <= s1_meta.kind;
    end
  end

endmodule

`default_nettype wire

@@ sv/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit values in a circular store.
// A result passes the result stage, then the output register, after its
// transaction is accepted. Throughput: one transaction per cycle while
// item_stall is low; a result stall reaches item_stall in the same cycle
// once the result stage and the output register are both occupied.
// Reset: synchronous; front pointer and count go to zero, the store keeps
// its contents, and no transaction is accepted while rst is high.
`default_nettype none

module double_ended_queue #(
  parameter int CAPACITY = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [2:0]         func,
  input  wire logic signed [31:0] data_value,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [31:0]      result_value,
  output logic [1:0]              result_kind
);
  import deq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic          accept, hold;
  logic          wr_en, rd_en;
  logic [AW-1:0] addr;
  logic [31:0]   rd_data;
  deq_meta_t     meta;

  assign item_stall = rst || hold;
  assign accept     = item_valid && !item_stall;

  deq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .func   (func),
    .wr_en  (wr_en),
    .rd_en  (rd_en),
    .addr   (addr),
    .meta   (meta)
  );

  deq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (data_value),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  deq_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .meta         (meta),
    .rd_data      (rd_data),
    .hold         (hold),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .result_kind  (result_kind)
  );

endmodule

`default_nettype wire

@@ sv/deq_checker.sv @@
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg.
`default_nettype none

module deq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_stall,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [31:0] result_value,
  input wire logic [1:0]         result_kind
);
  import deq_pkg::*;

  // A stalled result stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_value) && $stable(result_kind))
    else $error("result payload changed while stalled");

  // Reset empties the result channel
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  // Input back-pressure only comes from reset or a stalled, full result side
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> rst || (result_valid && result_stall))
    else $error("input stalled without downstream back-pressure");

  // Error results carry zero
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_UNDERFLOW || result_kind == KIND_OVERFLOW)
      |-> result_value == 32'sd0)
    else $error("error result with non-zero value");

endmodule

bind double_ended_queue deq_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_value (result_value),
  .result_kind  (result_kind)
);

`default_nettype wire
